// ----- hdl/anp_pkg.sv -----
// anp_pkg: types and constants shared by the ascii number parser modules
// holds the queue entry format, op kinds, base codes and character codes
// no dependencies
package anp_pkg;

    // what the back end does with one queued item
    typedef enum logic [1:0] {
        OP_DIGIT  = 2'd0,
        OP_PREFIX = 2'd1,
        OP_BAD    = 2'd2,
        OP_EMPTY  = 2'd3
    } t_op_kind;

    // one classified item as it travels from front to back
    typedef struct packed {
        t_op_kind    kind;
        logic        hex;
        logic [3:0]  digit;
        logic        last;
    } t_anp_op;

    // base select codes
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_DEC  = 2'd1;
    localparam logic [1:0] BASE_HEX  = 2'd2;
    localparam logic [1:0] BASE_BAD  = 2'd3;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

// ----- hdl/anp_queue.sv -----
// anp_queue: small first-in first-out queue of classified items
// sits between anp_front and anp_back, depends on anp_pkg
module anp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  anp_pkg::t_anp_op i_data,
    output logic             o_full,
    input  logic             i_pop,
    output anp_pkg::t_anp_op o_data,
    output logic             o_empty
);
    localparam int PTR_W = (anp_pkg::QUEUE_DEPTH > 1) ? $clog2(anp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(anp_pkg::QUEUE_DEPTH + 1);

    anp_pkg::t_anp_op r_mem [anp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(anp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(anp_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        n_wr_ptr = (i_push) ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = (i_pop)  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/anp_front.sv -----
// anp_front: classifies each character into a queue entry
// tracks position, leading zero and hex mode; depends on anp_pkg
module anp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    input  logic             i_empty,
    input  logic [1:0]       i_base,
    output anp_pkg::t_anp_op o_op
);
    logic [1:0] r_pos, n_pos;
    logic       r_first_zero, n_first_zero;
    logic       r_hex, n_hex;

    logic       w_hex_now;
    logic       w_prefix;
    logic       w_is_dec;
    logic       w_is_lo;
    logic       w_is_up;
    logic [3:0] w_digit;
    logic       w_valid_digit;

    // hex mode is latched from the base at the first character
    assign w_hex_now = (r_pos == 2'd0) ? (i_base == anp_pkg::BASE_HEX) : r_hex;

    assign w_prefix = (r_pos == 2'd1) && r_first_zero
                   && (i_char == anp_pkg::CH_LOW_X || i_char == anp_pkg::CH_UP_X)
                   && (i_base == anp_pkg::BASE_AUTO || i_base == anp_pkg::BASE_HEX);

    assign w_is_dec = (i_char >= anp_pkg::CH_ZERO)  && (i_char <= anp_pkg::CH_NINE);
    assign w_is_lo  = (i_char >= anp_pkg::CH_LOW_A) && (i_char <= anp_pkg::CH_LOW_F);
    assign w_is_up  = (i_char >= anp_pkg::CH_UP_A)  && (i_char <= anp_pkg::CH_UP_F);

    always_comb begin
        w_digit       = 4'd0;
        w_valid_digit = 1'b0;
        if (w_is_dec) begin
            w_digit       = 4'(i_char - anp_pkg::CH_ZERO);
            w_valid_digit = 1'b1;
        end else if (w_hex_now && w_is_lo) begin
            w_digit       = 4'(i_char - anp_pkg::CH_LOW_A + 8'd10);
            w_valid_digit = 1'b1;
        end else if (w_hex_now && w_is_up) begin
            w_digit       = 4'(i_char - anp_pkg::CH_UP_A + 8'd10);
            w_valid_digit = 1'b1;
        end
    end

    always_comb begin
        o_op.hex   = w_hex_now;
        o_op.digit = w_digit;
        o_op.last  = i_last;
        if (i_empty) begin
            o_op.kind = anp_pkg::OP_EMPTY;
        end else if (i_base == anp_pkg::BASE_BAD) begin
            o_op.kind = anp_pkg::OP_BAD;
        end else if (w_prefix) begin
            o_op.kind = anp_pkg::OP_PREFIX;
        end else if (w_valid_digit) begin
            o_op.kind = anp_pkg::OP_DIGIT;
        end else begin
            o_op.kind = anp_pkg::OP_BAD;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_first_zero = r_first_zero;
        n_hex        = r_hex;
        if (i_push) begin
            if (i_empty || i_last) begin
                n_pos        = 2'd0;
                n_first_zero = 1'b0;
                n_hex        = 1'b0;
            end else begin
                if (r_pos != 2'd2) begin
                    n_pos = r_pos + 2'd1;
                end
                if (r_pos == 2'd0) begin
                    n_first_zero = (i_char == anp_pkg::CH_ZERO);
                end
                n_hex = w_hex_now || (w_prefix && i_base != anp_pkg::BASE_BAD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 2'd0;
            r_first_zero <= 1'b0;
            r_hex        <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_first_zero <= n_first_zero;
            r_hex        <= n_hex;
        end
    end

endmodule

// ----- hdl/anp_back.sv -----
// anp_back: accumulates queued digits and holds the result register
// applies one queue entry per cycle unless a finishing entry waits for a free result slot; depends on anp_pkg
module anp_back #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  anp_pkg::t_anp_op       i_op,
    input  logic                   i_op_valid,
    output logic                   o_pop,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_error,
    output logic                   o_valid,
    input  logic                   i_ready
);
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_digit_seen, n_digit_seen;
    logic                   r_err_seen, n_err_seen;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic                   r_out_err, n_out_err;

    logic                   w_produces;
    logic                   w_slot_free;
    logic [VALUE_WIDTH-1:0] w_digit_ext;
    logic [VALUE_WIDTH-1:0] w_scaled;
    logic                   w_fail;

    assign w_produces  = i_op.last || (i_op.kind == anp_pkg::OP_EMPTY);
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_pop       = i_op_valid && (!w_produces || w_slot_free);
    assign w_digit_ext = VALUE_WIDTH'(i_op.digit);

    // times sixteen is a shift, times ten is 8x plus 2x
    assign w_scaled = i_op.hex ? (r_acc << 4) : ((r_acc << 3) + (r_acc << 1));

    always_comb begin
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_err_seen   = r_err_seen;
        case (i_op.kind)
            anp_pkg::OP_DIGIT: begin
                n_acc        = w_scaled + w_digit_ext;
                n_digit_seen = 1'b1;
            end
            anp_pkg::OP_PREFIX: begin
                n_acc        = '0;
                n_digit_seen = 1'b0;
            end
            anp_pkg::OP_BAD: begin
                n_err_seen = 1'b1;
            end
            anp_pkg::OP_EMPTY: begin
                n_err_seen = 1'b1;
            end
            default: begin
                n_err_seen = 1'b1;
            end
        endcase
    end

    assign w_fail = (i_op.kind == anp_pkg::OP_EMPTY) || n_err_seen || !n_digit_seen;

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        if (o_pop && w_produces) begin
            n_out_valid = 1'b1;
            n_out_value = w_fail ? '0 : n_acc;
            n_out_err   = w_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_err_seen   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (w_produces) begin
                    r_acc        <= '0;
                    r_digit_seen <= 1'b0;
                    r_err_seen   <= 1'b0;
                end else begin
                    r_acc        <= n_acc;
                    r_digit_seen <= n_digit_seen;
                    r_err_seen   <= n_err_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    assign o_value = r_out_value;
    assign o_error = r_out_err;
    assign o_valid = r_out_valid;

endmodule

// ----- hdl/ascii_number_parser.sv -----
// ascii_number_parser: an accepted last or empty item goes through the queue to the result register
// throughput is one character per cycle while the queue is not full, set by the shift-add accumulator
// the two-entry queue lets the front keep taking items while the result register is stalled
// reset (i_rst_n low, synchronous) clears string state, queue, result valid and base to automatic
// depends on anp_pkg, anp_queue, anp_front and anp_back
module ascii_number_parser #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // characters in
    input  logic                                 i_tvalid,
    output logic                                 o_tready,
    input  logic [7:0]                           i_tdata,  // char_code
    input  logic                                 i_tlast,  // last_char
    input  logic                                 i_tuser,  // empty_string
    // results out
    output logic                                 o_tvalid,
    input  logic                                 i_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]     o_tdata,  // parsed_value, zero pad
    output logic                                 o_tuser,  // parse_error
    // base select register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_data   // base_select
);
    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic [1:0]             r_base;
    logic                   w_accept;
    logic                   w_q_full;
    logic                   w_q_empty;
    logic                   w_pop;
    anp_pkg::t_anp_op       w_front_op;
    anp_pkg::t_anp_op       w_head_op;
    logic [VALUE_WIDTH-1:0] w_value;

    // config register is always writable; user must write it only while idle (not enforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= anp_pkg::BASE_AUTO;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    // input side stalls only on a full queue
    assign o_tready = !w_q_full;
    assign w_accept = i_tvalid && o_tready;

    // front: position tracking, prefix detection, digit decode
    anp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_char  (i_tdata),
        .i_last  (i_tlast),
        .i_empty (i_tuser),
        .i_base  (r_base),
        .o_op    (w_front_op)
    );

    // decoupling queue between classification and accumulation
    anp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_op),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_head_op),
        .o_empty (w_q_empty)
    );

    // back: accumulator and result register
    anp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_head_op),
        .i_op_valid (!w_q_empty),
        .o_pop      (w_pop),
        .o_value    (w_value),
        .o_error    (o_tuser),
        .o_valid    (o_tvalid),
        .i_ready    (i_tready)
    );

    assign o_tdata = TDATA_W'(w_value);

    // an error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser) |-> (w_value == '0))
        else $error("error result with nonzero value");

    // the queue cannot be full and empty at once
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("queue full and empty together");

    // nothing is popped from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_empty |-> !w_pop)
        else $error("pop from empty queue");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tvalid)
        else $error("result valid after reset");

endmodule

// ----- tb/ascii_number_parser_test.sv -----
// ascii_number_parser_test: self-checking bench for the streaming ascii number parser
// predicts each result from the accepted characters and the base register, then checks it
// depends on anp_pkg and ascii_number_parser
module ascii_number_parser_test;

    localparam int ITEM_TARGET = 1500;  // stop issuing strings past this many items
    localparam int TAIL_ITEMS  = 200;   // final stretch runs with no idling on either side
    localparam int SETTLE_CYC  = 8;     // margin for the pipe to go quiet after the last result
    localparam int HOLD_CYC    = 150;   // long receiver hold-off to back up the input

    // one expected or observed result
    typedef struct packed {
        logic [63:0] value;
        logic        err;
    } t_parse_result;

    // predicts results from accepted items and checks them in order
    class number_scoreboard;
        logic [1:0]    base;
        logic [63:0]   acc;
        int            pos;
        logic          first_zero;
        logic          hex_on;
        logic          seen_digit;
        logic          seen_bad;
        int            errors;
        t_parse_result expected_numbers[$];

        function new();
            base   = anp_pkg::BASE_AUTO;
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            acc        = '0;
            pos        = 0;
            first_zero = 1'b0;
            hex_on     = 1'b0;
            seen_digit = 1'b0;
            seen_bad   = 1'b0;
        endfunction

        // digit weight of a character, -1 if it is no digit in the current radix
        function int digit_value(logic [7:0] c, logic hex);
            if (c >= anp_pkg::CH_ZERO && c <= anp_pkg::CH_NINE)
                return int'(c - anp_pkg::CH_ZERO);
            if (hex && c >= anp_pkg::CH_LOW_A && c <= anp_pkg::CH_LOW_F)
                return int'(c - anp_pkg::CH_LOW_A) + 10;
            if (hex && c >= anp_pkg::CH_UP_A && c <= anp_pkg::CH_UP_F)
                return int'(c - anp_pkg::CH_UP_A) + 10;
            return -1;
        endfunction

        function void note_item(logic [7:0] c, logic last, logic empty);
            t_parse_result r;
            logic          is_prefix;
            int            d;
            if (empty) begin
                // empty marker always ends the string with an error
                r.value = '0;
                r.err   = 1'b1;
                expected_numbers.push_back(r);
                clear_string();
                return;
            end
            if (pos == 0) begin
                hex_on     = (base == anp_pkg::BASE_HEX);
                first_zero = (c == anp_pkg::CH_ZERO);
            end
            is_prefix = (pos == 1) && first_zero &&
                        (c == anp_pkg::CH_LOW_X || c == anp_pkg::CH_UP_X) &&
                        (base == anp_pkg::BASE_AUTO || base == anp_pkg::BASE_HEX);
            if (base == anp_pkg::BASE_BAD) begin
                seen_bad = 1'b1;
            end else if (is_prefix) begin
                hex_on     = 1'b1;
                seen_digit = 1'b0;
                acc        = '0;
            end else begin
                d = digit_value(c, hex_on);
                if (d < 0) begin
                    seen_bad = 1'b1;
                end else begin
                    // wraps modulo 2^64 through the 64-bit assignment
                    acc        = (hex_on ? (acc << 4) : (acc * 64'd10)) + 64'(d);
                    seen_digit = 1'b1;
                end
            end
            if (pos < 2)
                pos++;
            if (last) begin
                r.err   = seen_bad || !seen_digit;
                r.value = r.err ? 64'd0 : acc;
                expected_numbers.push_back(r);
                clear_string();
            end
        endfunction

        function void check_result(logic [63:0] value, logic err);
            t_parse_result exp_r;
            if (expected_numbers.size() == 0) begin
                $display("%0t: unexpected result value %h error %b", $time, value, err);
                errors++;
                return;
            end
            exp_r = expected_numbers.pop_front();
            if (value !== exp_r.value) begin
                $display("%0t: parsed_value mismatch, expected %h, got %h",
                         $time, exp_r.value, value);
                errors++;
            end
            if (err !== exp_r.err) begin
                $display("%0t: parse_error mismatch, expected %b, got %b",
                         $time, exp_r.err, err);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_tvalid;
    logic        o_tready;
    logic [7:0]  i_tdata;   // char_code
    logic        i_tlast;   // last_char
    logic        i_tuser;   // empty_string
    logic        o_tvalid;
    logic        i_tready;
    logic [63:0] o_tdata;   // parsed_value
    logic        o_tuser;   // parse_error
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data;  // base_select

    number_scoreboard sb;
    int items_sent;
    int tx_gap_pct;    // chance per item of a sender gap
    int rx_stall_pct;  // chance per cycle of a receiver stall burst
    int rx_hold_len;   // nonzero asks the receiver for one long hold-off

    ascii_number_parser #(
        .VALUE_WIDTH (64)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_tvalid),
        .o_tready    (o_tready),
        .i_tdata     (i_tdata),
        .i_tlast     (i_tlast),
        .i_tuser     (i_tuser),
        .o_tvalid    (o_tvalid),
        .i_tready    (i_tready),
        .o_tdata     (o_tdata),
        .o_tuser     (o_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: ready drops in random bursts, or for one long hold-off on request
    initial begin
        int stall_left;
        i_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_tready <= 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
                i_tready <= 1'b1;
            end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
                i_tready <= 1'b0;
                // a burst ends early once idling is switched off
                stall_left = $urandom_range(1, 19);
                while (stall_left > 0 && rx_stall_pct > 0) begin
                    @(negedge i_clk);
                    stall_left--;
                end
                i_tready <= 1'b1;
            end else begin
                i_tready <= 1'b1;
            end
        end
    end

    // every accepted result goes to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_tvalid && i_tready)
            sb.check_result(o_tdata, o_tuser);
    end

    // offer one item, with an optional gap first; valid stays up after acceptance
    task automatic send_char(input logic [7:0] c, input logic last, input logic empty);
        @(negedge i_clk);
        if ($urandom_range(1, 100) <= tx_gap_pct) begin
            i_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= c;
        i_tlast  <= last;
        i_tuser  <= empty;
        do @(posedge i_clk); while (!o_tready);
        sb.note_item(c, last, empty);
        items_sent++;
    endtask

    // empty marker, the character byte is junk that must be ignored
    task automatic send_empty(input logic last);
        send_char(8'($urandom_range(0, 255)), last, 1'b1);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1, 1'b0);
    endtask

    // drop valid, let every result drain and the pipe go quiet
    task automatic settle();
        @(negedge i_clk);
        i_tvalid <= 1'b0;
        while (sb.expected_numbers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [1:0] b);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= b;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.base = b;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] dec_char();
        return anp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // random hex digit in either case
    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return anp_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? anp_pkg::CH_UP_A : anp_pkg::CH_LOW_A) + 8'(v - 10);
    endfunction

    // mostly well-formed numbers with random digits, the rest noise and broken strings
    task automatic send_random_string();
        logic [7:0] text[$];
        int         kind;
        int         len;
        kind = $urandom_range(0, 11);
        // long strings now and then so the accumulator wraps
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        case (kind)
            0, 1, 2: begin
                repeat (len) text.push_back(dec_char());
            end
            3, 4, 5: begin
                text.push_back(anp_pkg::CH_ZERO);
                text.push_back($urandom_range(0, 1) ? anp_pkg::CH_UP_X : anp_pkg::CH_LOW_X);
                repeat (len) text.push_back(hex_char());
            end
            6: begin
                repeat (len) text.push_back(hex_char());
            end
            7: begin
                // one corrupted byte somewhere in a number
                repeat (len) text.push_back(dec_char());
                text[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
            end
            8: begin
                repeat (len) text.push_back(8'($urandom_range(0, 255)));
            end
            9: begin
                // lone zero, or a prefix with nothing after it
                text.push_back(anp_pkg::CH_ZERO);
                if ($urandom_range(0, 1))
                    text.push_back($urandom_range(0, 1) ? anp_pkg::CH_UP_X
                                                        : anp_pkg::CH_LOW_X);
            end
            10: begin
                send_empty($urandom_range(0, 1));
                return;
            end
            default: begin
                // string cut short by an empty marker
                repeat ($urandom_range(1, 4)) send_char(hex_char(), 1'b0, 1'b0);
                send_empty($urandom_range(0, 1));
                return;
            end
        endcase
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1, 1'b0);
    endtask

    function automatic logic [1:0] pick_base();
        case ($urandom_range(0, 6))
            0, 1:    return anp_pkg::BASE_AUTO;
            2, 3:    return anp_pkg::BASE_DEC;
            4, 5:    return anp_pkg::BASE_HEX;
            default: return anp_pkg::BASE_BAD;
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 30;
        endcase
    endfunction

    initial begin
        int  phase;
        logic tail;
        sb           = new();
        items_sent   = 0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_len  = 0;
        i_rst_n      = 1'b0;
        i_tvalid     = 1'b0;
        i_tdata      = '0;
        i_tlast      = 1'b0;
        i_tuser      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = anp_pkg::BASE_AUTO;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: automatic base out of reset
        send_str("0");
        send_str("0X1f");
        send_str("0x");
        send_str("12");
        send_empty(1'b1);
        settle();
        // decimal: x is no digit here, empty marker without last
        write_base(anp_pkg::BASE_DEC);
        send_str("9");
        send_str("0x");
        send_empty(1'b0);
        settle();
        // hex: both cases, byte extremes, lone zero, string dropped by empty marker
        write_base(anp_pkg::BASE_HEX);
        send_str("fA");
        send_char(8'hff, 1'b1, 1'b0);
        send_char(8'h00, 1'b1, 1'b0);
        send_str("0");
        send_char(dec_char(), 1'b0, 1'b0);
        send_empty(1'b1);
        settle();
        // unsupported base fails even on a valid digit
        write_base(anp_pkg::BASE_BAD);
        send_str("7");
        settle();
        write_base(anp_pkg::BASE_AUTO);

        // random phases, each under its own base and idling mix
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            tail         = (items_sent > ITEM_TARGET - TAIL_ITEMS);
            tx_gap_pct   = tail ? 0 : pick_pct();
            rx_stall_pct = tail ? 0 : pick_pct();
            if (phase == 1) begin
                // long hold-off on the result side while single-digit strings keep coming
                tx_gap_pct  = 0;
                rx_hold_len = HOLD_CYC;
                repeat (30) send_char(dec_char(), 1'b1, 1'b0);
            end
            repeat ($urandom_range(5, 25)) send_random_string();
            // sometimes leave a string open so the base changes under it
            if (!tail && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_char(hex_char(), 1'b0, 1'b0);
            settle();
            write_base(pick_base());
        end

        // close any open string, then let everything drain
        send_char(dec_char(), 1'b1, 1'b0);
        settle();
        if (sb.errors == 0 && sb.expected_numbers.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
